// ----- sv/trlc_pkg.sv -----
// shared types and constants for the tagged run-length word codec
// no dependencies; imported by the core, queue and top-level modules

package trlc_pkg;

    localparam int WORD_W      = 16;
    localparam int COUNT_W     = 15;
    localparam int MAX_RESULTS = 4;
    localparam int QUEUE_DEPTH = 16;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;
    localparam int RCNT_W      = 3;

    localparam logic [COUNT_W-1:0] MAX_RUN       = 15'd32767;
    localparam logic [COUNT_W-1:0] LITERAL_LIMIT = 15'd3;
    localparam logic [WORD_W-1:0]  TAG_RESET     = 16'hFFFF;

    // configuration register indexes
    localparam logic CFG_DIRECTION  = 1'b0;
    localparam logic CFG_ESCAPE_TAG = 1'b1;

    // direction codes
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic [COUNT_W-1:0] rep;
        logic               run_last;
        logic               chunk_end;
    } t_result;

    typedef struct packed {
        t_result [MAX_RESULTS-1:0] res;
        logic [RCNT_W-1:0]         cnt;
    } t_batch;

endpackage

// ----- sv/trlc_core.sv -----
// input register, codec state and result generation for one accepted item per cycle
// depends on trlc_pkg

module trlc_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_accept,
    input  logic [15:0]           i_in_word,
    input  logic                  i_in_end,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_addr,
    input  logic [15:0]           i_cfg_wdata,
    output trlc_pkg::t_batch      o_batch
);
    import trlc_pkg::*;

    typedef enum logic [1:0] {
        PH_PLAIN,
        PH_COUNT,
        PH_VALUE
    } t_phase;

    typedef struct packed {
        logic [2:0][WORD_W-1:0] w;
        logic [1:0]             n;
    } t_close;

    logic                r_in_valid;
    logic [WORD_W-1:0]   r_in_word;
    logic                r_in_end;
    logic                r_direction;
    logic [WORD_W-1:0]   r_escape_tag;
    logic [WORD_W-1:0]   r_run_value;
    logic [COUNT_W-1:0]  r_run_length;
    t_phase              r_phase;
    logic [WORD_W-1:0]   r_pending;

    logic [WORD_W-1:0]   n_run_value;
    logic [COUNT_W-1:0]  n_run_length;
    t_phase              n_phase;
    logic [WORD_W-1:0]   n_pending;

    t_close              seg_a;
    t_close              seg_b;
    logic                close_old;
    logic                cap_hit;
    logic [COUNT_W-1:0]  base_len;
    logic [RCNT_W-1:0]   na;
    logic [RCNT_W-1:0]   nb;
    logic [RCNT_W-1:0]   idx;
    logic [WORD_W-1:0]   words [MAX_RESULTS];
    logic [COUNT_W-1:0]  reps  [MAX_RESULTS];
    logic [RCNT_W-1:0]   total;

    function automatic t_close close_seq(logic [COUNT_W-1:0] len,
                                         logic [WORD_W-1:0] val,
                                         logic [WORD_W-1:0] tag);
        t_close c;
        c.w = '0;
        c.n = '0;
        if (len > LITERAL_LIMIT) begin
            c.w[0] = tag;
            c.w[1] = {1'b0, len};
            c.w[2] = val;
            c.n    = 2'd3;
        end else begin
            c.w[0] = val;
            c.w[1] = val;
            c.w[2] = val;
            c.n    = len[1:0];
        end
        return c;
    endfunction

    always_comb begin
        n_run_value  = r_run_value;
        n_run_length = r_run_length;
        n_phase      = r_phase;
        n_pending    = r_pending;
        seg_a        = '0;
        seg_b        = '0;
        close_old    = 1'b0;
        cap_hit      = 1'b0;
        base_len     = '0;
        na           = '0;
        nb           = '0;
        idx          = '0;
        total        = '0;
        for (int j = 0; j < MAX_RESULTS; j++) begin
            words[j] = '0;
            reps[j]  = '0;
        end

        if (r_direction == DIR_ENCODE) begin
            close_old = (r_run_length != '0) && (r_in_word != r_run_value);
            if (close_old) begin
                seg_a = close_seq(r_run_length, r_run_value, r_escape_tag);
            end
            base_len = (close_old || r_run_length == '0) ? COUNT_W'(1)
                                                         : r_run_length + COUNT_W'(1);
            cap_hit  = base_len >= MAX_RUN;
            // cap and chunk end both close the current run, at most once
            if (cap_hit || r_in_end) begin
                seg_b = close_seq(base_len, r_in_word, r_escape_tag);
            end
            n_run_value  = r_in_word;
            n_run_length = (cap_hit || r_in_end) ? '0 : base_len;
            na = {1'b0, seg_a.n};
            nb = {1'b0, seg_b.n};
            total = na + nb;
            for (int j = 0; j < MAX_RESULTS; j++) begin
                reps[j] = COUNT_W'(1);
                idx     = RCNT_W'(j) - na;
                if (RCNT_W'(j) < na) begin
                    words[j] = seg_a.w[j[1:0]];
                end else if (idx < nb) begin
                    words[j] = seg_b.w[idx[1:0]];
                end
            end
        end else begin
            unique case (r_phase)
                PH_COUNT: begin
                    n_pending = r_in_word;
                    n_phase   = PH_VALUE;
                end
                PH_VALUE: begin
                    if (r_pending != '0 && !r_pending[WORD_W-1]) begin
                        words[0] = r_in_word;
                        reps[0]  = r_pending[COUNT_W-1:0];
                        total    = RCNT_W'(1);
                    end
                    n_phase = PH_PLAIN;
                end
                default: begin
                    if (r_in_word == r_escape_tag) begin
                        n_phase = PH_COUNT;
                    end else begin
                        words[0] = r_in_word;
                        reps[0]  = COUNT_W'(1);
                        total    = RCNT_W'(1);
                        n_phase  = PH_PLAIN;
                    end
                end
            endcase
            if (r_in_end) begin
                n_phase = PH_PLAIN;
                // bare end marker: word 0, repeat 0
                if (total == '0) begin
                    words[0] = '0;
                    reps[0]  = '0;
                    total    = RCNT_W'(1);
                end
            end
        end
    end

    always_comb begin
        o_batch.cnt = r_in_valid ? total : '0;
        for (int j = 0; j < MAX_RESULTS; j++) begin
            o_batch.res[j].word      = words[j];
            o_batch.res[j].rep       = reps[j];
            o_batch.res[j].run_last  = (RCNT_W'(j + 1) == total);
            o_batch.res[j].chunk_end = (RCNT_W'(j + 1) == total) && r_in_end;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_word <= i_in_word;
        r_in_end  <= i_in_end;
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_direction  <= DIR_ENCODE;
            r_escape_tag <= TAG_RESET;
            r_run_value  <= '0;
            r_run_length <= '0;
            r_phase      <= PH_PLAIN;
            r_pending    <= '0;
        end else begin
            r_in_valid <= i_in_accept;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_DIRECTION:  r_direction  <= i_cfg_wdata[0];
                    CFG_ESCAPE_TAG: r_escape_tag <= i_cfg_wdata;
                    default:        r_direction  <= r_direction;
                endcase
            end
            if (r_in_valid) begin
                r_run_value  <= n_run_value;
                r_run_length <= n_run_length;
                r_phase      <= n_phase;
                r_pending    <= n_pending;
            end
        end
    end

endmodule

// ----- sv/trlc_queue.sv -----
// result queue: takes up to four results per cycle, gives one per transfer
// depends on trlc_pkg

module trlc_queue (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  trlc_pkg::t_batch               i_batch,
    input  logic                           i_pop,
    output logic                           o_valid,
    output trlc_pkg::t_result              o_head,
    output logic [trlc_pkg::QCNT_W-1:0]    o_level
);
    import trlc_pkg::*;

    t_result             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_level;
    logic                do_pop;

    assign do_pop  = i_pop && (r_level != '0);
    assign o_valid = r_level != '0;
    assign o_head  = r_mem[r_rd_ptr];
    assign o_level = r_level;

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < MAX_RESULTS; j++) begin
            if (RCNT_W'(j) < i_batch.cnt) begin
                r_mem[r_wr_ptr + QPTR_W'(j)] <= i_batch.res[j];
            end
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + QPTR_W'(i_batch.cnt);
            r_rd_ptr <= r_rd_ptr + QPTR_W'(do_pop);
            r_level  <= r_level + QCNT_W'(i_batch.cnt) - QCNT_W'(do_pop);
        end
    end

endmodule

// ----- sv/tagged_rle_word_codec.sv -----
// Tagged run-length word codec, top level: input register, codec core, result queue.
// An accepted word is held in the core input register; its results are written into
// the result queue, from which they are offered.
// Throughput: one input word per cycle while the 16-entry result queue has room;
// results leave one per cycle while the sink is ready, so bursts of up to four results per word queue up.
// Reset (i_rst_n low, synchronous) clears run, phase and queue state and sets
// direction to encode and the escape tag to 0xFFFF.

module tagged_rle_word_codec (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] in_word
    input  logic        s_axis_tlast,   // in_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] out_word, [30:16] repeat_count, [31] zero
    output logic        m_axis_tuser,   // run_last
    output logic        m_axis_tlast,   // chunk_end
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [15:0] i_cfg_wdata
);
    import trlc_pkg::*;

    t_batch              batch;
    t_result             head;
    logic [QCNT_W-1:0]   level;
    logic [QCNT_W:0]     committed;
    logic                in_accept;

    // room for the word in flight and one more worst-case burst
    assign committed     = {1'b0, level} + (QCNT_W + 1)'(batch.cnt);
    assign s_axis_tready = committed <= (QCNT_W + 1)'(QUEUE_DEPTH - MAX_RESULTS);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    trlc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_accept (in_accept),
        .i_in_word   (s_axis_tdata),
        .i_in_end    (s_axis_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_batch     (batch)
    );

    trlc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_batch (batch),
        .i_pop   (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_head  (head),
        .o_level (level)
    );

    assign m_axis_tdata = {1'b0, head.rep, head.word};
    assign m_axis_tuser = head.run_last;
    assign m_axis_tlast = head.chunk_end;

endmodule

// ----- sv/trlc_checker.sv -----
// port-level checks for the tagged run-length word codec, bound to the top level
// depends on tagged_rle_word_codec ports only

module trlc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [15:0] s_axis_tdata,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast,
    input logic        i_cfg_we,
    input logic        i_cfg_addr,
    input logic [15:0] i_cfg_wdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // end of chunk is always the last result of its word
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
        else $error("chunk end without run last");

    // repeat of zero only on the bare end marker
    a_zero_rep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[30:16] == 15'd0 |->
            m_axis_tlast && m_axis_tdata[15:0] == 16'd0)
        else $error("zero repeat on a non-marker result");

    // nothing is offered right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result offered after reset");

endmodule

bind tagged_rle_word_codec trlc_checker u_trlc_checker (.*);

// ----- tb/tagged_rle_word_codec_tb.sv -----
// self-checking testbench for the tagged run-length word codec
// depends on trlc_pkg and tagged_rle_word_codec; keeps its own codec state to
// work out the results of each word transfer and checks them as they arrive

module tagged_rle_word_codec_tb;
    import trlc_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [15:0] word;
        logic        last;
    } t_word_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;    // [15:0] in_word
    logic        s_axis_tlast = 1'b0;  // in_end
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // [15:0] out_word, [30:16] repeat_count, [31] zero
    logic        m_axis_tuser;         // run_last
    logic        m_axis_tlast;         // chunk_end
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_addr = 1'b0;
    logic [15:0] i_cfg_wdata = '0;

    tagged_rle_word_codec dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // codec state as the block should hold it
    logic               cfg_dir;
    logic [15:0]        cfg_tag;
    logic [15:0]        enc_value;
    logic [COUNT_W-1:0] enc_len;
    logic [1:0]         dec_phase;
    logic [15:0]        dec_count;

    t_result    step_out [0:MAX_RESULTS-1];
    int         step_n;
    t_result    owed_results [$];
    t_word_item words_to_send [$];

    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int errors = 0;
    int cycles = 0;
    int words_in = 0;
    int results_seen = 0;

    function automatic void put_res(input logic [15:0] w, input logic [COUNT_W-1:0] rep);
        step_out[step_n] = '{word: w, rep: rep, run_last: 1'b0, chunk_end: 1'b0};
        step_n++;
    endfunction

    function automatic void close_run();
        if (enc_len > 3) begin
            put_res(cfg_tag, COUNT_W'(1));
            put_res({1'b0, enc_len}, COUNT_W'(1));
            put_res(enc_value, COUNT_W'(1));
        end else begin
            for (int i = 0; i < enc_len; i++) put_res(enc_value, COUNT_W'(1));
        end
        enc_len = '0;
    endfunction

    function automatic void codec_step(input logic [15:0] w, input logic chunk_done);
        step_n = 0;
        if (cfg_dir == DIR_ENCODE) begin
            if (enc_len != 0 && w != enc_value) close_run();
            if (enc_len == 0) begin
                enc_value = w;
                enc_len   = COUNT_W'(1);
            end else begin
                enc_len = enc_len + 1'b1;
            end
            if (enc_len >= MAX_RUN) close_run();
            if (chunk_done) close_run();
        end else begin
            case (dec_phase)
                2'd1: begin
                    dec_count = w;
                    dec_phase = 2'd2;
                end
                2'd2: begin
                    // zero or negative counts swallow the whole triple
                    if (dec_count != 0 && !dec_count[15]) put_res(w, dec_count[14:0]);
                    dec_phase = 2'd0;
                end
                default: begin
                    if (w == cfg_tag) dec_phase = 2'd1;
                    else put_res(w, COUNT_W'(1));
                end
            endcase
            if (chunk_done) begin
                dec_phase = 2'd0;
                if (step_n == 0) put_res(16'h0000, '0);
            end
        end
        if (step_n > 0) begin
            step_out[step_n-1].run_last  = 1'b1;
            step_out[step_n-1].chunk_end = chunk_done;
        end
        for (int i = 0; i < step_n; i++) owed_results.push_back(step_out[i]);
    endfunction

    task automatic flag(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        if (errors <= 25)
            $display("mismatch at cycle %0d: %s got %0h want %0h", cycles, what, got, want);
    endtask

    // input side: one word transfer per handshake, fed from words_to_send
    logic       src_hold;
    t_word_item src_next;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
        end else begin
            src_hold = s_axis_tvalid && !s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                codec_step(s_axis_tdata, s_axis_tlast);
                words_in++;
            end
            if (!src_hold) begin
                if (words_to_send.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    src_next = words_to_send.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= src_next.word;
                    s_axis_tlast  <= src_next.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // output side: random stalls, every result transfer checked in order
    t_result got_res;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (owed_results.size() == 0) begin
                    flag("result with none owed", m_axis_tdata, 32'h0);
                end else begin
                    got_res = owed_results.pop_front();
                    if (m_axis_tdata[15:0] != got_res.word)
                        flag("out_word", m_axis_tdata[15:0], got_res.word);
                    if (m_axis_tdata[30:16] != got_res.rep)
                        flag("repeat_count", m_axis_tdata[30:16], got_res.rep);
                    if (m_axis_tdata[31] !== 1'b0)
                        flag("pad bit", m_axis_tdata[31], 32'h0);
                    if (m_axis_tuser !== got_res.run_last)
                        flag("run_last", m_axis_tuser, got_res.run_last);
                    if (m_axis_tlast !== got_res.chunk_end)
                        flag("chunk_end", m_axis_tlast, got_res.chunk_end);
                end
            end
            m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout with %0d results still owed", owed_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send(input logic [15:0] w, input logic last = 1'b0);
        words_to_send.push_back('{word: w, last: last});
    endtask

    // wait until the block has taken everything and delivered every result
    task automatic settle();
        do @(negedge i_clk);
        while (words_to_send.size() != 0 || s_axis_tvalid || owed_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_DIRECTION) cfg_dir = val[0];
        else cfg_tag = val;
    endtask

    function automatic logic [15:0] pick_value();
        int r;
        r = $urandom_range(9);
        case (r)
            0: return cfg_tag;
            1: return 16'h0000;
            2: return 16'h8000;
            3: return 16'h7FFF;
            4, 5: return 16'($urandom_range(3));
            default: return 16'($urandom);
        endcase
    endfunction

    // raw words grouped into runs so that both literals and escapes come out
    task automatic fill_raw(input int n);
        int sent;
        int r;
        int len;
        logic [15:0] v;
        sent = 0;
        while (sent < n) begin
            r = $urandom_range(99);
            if (r < 60) len = $urandom_range(1, 3);
            else if (r < 90) len = $urandom_range(4, 12);
            else len = $urandom_range(13, 40);
            v = pick_value();
            for (int i = 0; i < len; i++) send(v, $urandom_range(99) < 4);
            sent += len;
        end
    endtask

    // mostly well-formed escapes and literals, some bare tags and noise
    task automatic fill_coded(input int n);
        int sent;
        int r;
        int c;
        logic [15:0] cnt;
        sent = 0;
        while (sent < n) begin
            r = $urandom_range(99);
            if (r < 55) begin
                c = $urandom_range(99);
                if (c < 65) cnt = 16'($urandom_range(1, 40));
                else if (c < 73) cnt = 16'h0000;
                else if (c < 83) cnt = 16'h8000 | 16'($urandom_range(32767));
                else if (c < 88) cnt = 16'h7FFF;
                else cnt = 16'($urandom);
                send(cfg_tag, $urandom_range(99) < 3);
                send(cnt, $urandom_range(99) < 3);
                send(pick_value(), $urandom_range(99) < 6);
                sent += 3;
            end else if (r < 90) begin
                send(16'($urandom), $urandom_range(99) < 6);
                sent++;
            end else begin
                send(cfg_tag, $urandom_range(99) < 30);
                sent++;
            end
        end
    endtask

    logic [15:0] phase_tags [0:3];

    initial begin
        cfg_dir   = DIR_ENCODE;
        cfg_tag   = TAG_RESET;
        enc_value = '0;
        enc_len   = '0;
        dec_phase = '0;
        dec_count = '0;
        phase_tags[0] = 16'h8000;
        phase_tags[1] = 16'h7FFF;
        phase_tags[2] = 16'h0000;
        phase_tags[3] = 16'($urandom);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // compress from reset: lone extreme, escaped run, tag-valued literals
        send(16'h8000, 1'b1);
        repeat (4) send(16'h7FFF);
        repeat (3) send(16'hFFFF);
        send(16'h0001, 1'b1);
        send(16'h2222);
        settle();

        // expand with an open compress run left behind
        write_reg(CFG_DIRECTION, 16'(DIR_DECODE));
        send(16'hFFFF); send(16'h0005); send(16'hABCD);
        send(16'hFFFF); send(16'h0000); send(16'h1111);
        send(16'hFFFF); send(16'h8000); send(16'h1111);
        send(16'hFFFF); send(16'h7FFF); send(16'h5555, 1'b1);
        send(16'hFFFF, 1'b1);
        send(16'hFFFF); send(16'h0003, 1'b1);
        send(16'h4321, 1'b1);
        send(16'hFFFF);
        settle();

        // the open run resumes, then the open escape resumes
        write_reg(CFG_DIRECTION, 16'(DIR_ENCODE));
        repeat (2) send(16'h2222);
        send(16'h2222, 1'b1);
        settle();
        write_reg(CFG_DIRECTION, 16'(DIR_DECODE));
        send(16'h0002); send(16'h7777, 1'b1);
        settle();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 69; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 69; end
                default: begin src_idle_pct = 38; snk_stall_pct = 38; end
            endcase
            write_reg(CFG_ESCAPE_TAG, phase_tags[p]);
            write_reg(CFG_DIRECTION, 16'(DIR_ENCODE));
            fill_raw(50);
            settle();
            write_reg(CFG_DIRECTION, 16'(DIR_DECODE));
            fill_coded(50);
            settle();
        end

        $display("sent %0d words and checked %0d results in both directions", words_in,
                 results_seen);
        $display("covered direction switches, four escape tags and four idle patterns");
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", errors);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
